@@ rtl/c2e_pkg.sv @@
// Shared constants, codes and control types of the COO to ELL scatter block.
package c2e_pkg;

    localparam int MAX_ROWS    = 4096;
    localparam int MAX_ROW_LEN = 1024;

    localparam int ROW_AW  = $clog2(MAX_ROWS);
    localparam int CNT_W   = 11;
    localparam int ROW_W   = 13;
    localparam int COL_W   = 31;
    localparam int VAL_W   = 64;
    localparam int PITCH_W = 13;
    localparam int EB_W    = 5;
    localparam int SLOT_W  = 22;
    localparam int OFF_W   = 26;
    localparam int COLO_W  = 33;
    localparam int STAT_W  = 2;
    localparam int PROD_W  = CNT_W + PITCH_W;

    localparam int S_DATA_W  = 112;
    localparam int M_DATA_W  = 152;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 13;

    localparam logic [CFG_IDX_W-1:0] REG_COO_BASE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELL_BASE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ROW_SIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_PITCH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_PITCH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_BYTES = 3'd6;

    localparam logic [STAT_W-1:0] ST_WRITTEN   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ROW_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_ROW_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_CLEARED   = 2'd3;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_ADD   = 7'b0010000,
        S_SCALE = 7'b0100000,
        S_PUSH  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic mul;
        logic add;
        logic scale;
        logic push;
    } dp_cmd_t;

    typedef struct packed {
        logic in_clear;
        logic clear_done;
        logic out_busy;
    } dp_stat_t;

endpackage

@@ rtl/coo_to_ell_scatter.sv @@
// Top level of the COO to ELL scatter block.
// Each coordinate request passes from acceptance to result through the steps
// accept, counter read, multiply, add, scale and push, set by the registered-read
// counter memory and the staged multiply, add and scale steps; the next request is taken
// once the previous result is registered, even if that result is still waiting
// on m_tready. A clear request, and reset, run a sweep over all 4096 rows of the
// row counter memory; no request is accepted during the sweep, and a clear
// request's result follows it. Configuration writes are taken at any time.
module coo_to_ell_scatter
    import c2e_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // row_index, col_index, value_in
    input  logic                 s_tuser,   // command
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // index_slot, value_byte_offset, column_out, value_out
    output logic [STAT_W-1:0]    m_tuser,   // status
    output logic                 m_tlast
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    c2e_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    c2e_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

@@ rtl/c2e_ram.sv @@
// Generic single-port-write, registered-read RAM.
module c2e_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/c2e_dp.sv @@
// Datapath: configuration registers, row counter store, offset arithmetic, output register.
module c2e_dp
    import c2e_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,
    output logic [STAT_W-1:0]    m_tuser,
    output logic                 m_tlast
);

    logic               coo_base_reg;
    logic               ell_base_reg;
    logic [ROW_W-1:0]   rows_count_reg;
    logic [CNT_W-1:0]   max_row_size_reg;
    logic [PITCH_W-1:0] value_pitch_reg;
    logic [PITCH_W-1:0] index_pitch_reg;
    logic [EB_W-1:0]    element_bytes_reg;

    logic               cmd_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic [VAL_W-1:0]   val_reg;
    logic               last_reg;

    logic [ROW_AW-1:0]  clr_addr_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [PROD_W-1:0]  prod_i_reg;
    logic [PROD_W-1:0]  prod_v_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [OFF_W-1:0]   sumv_reg;
    logic [OFF_W-1:0]   off_reg;

    logic               m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [STAT_W-1:0]  m_tuser_reg;
    logic               m_tlast_reg;

    logic [ROW_W-1:0]   row_rb;
    logic               row_bad;
    logic [CNT_W-1:0]   pos;
    logic [CNT_W-1:0]   len_lim;
    logic               row_full;
    logic               ram_we;
    logic [ROW_AW-1:0]  ram_waddr;
    logic [CNT_W-1:0]   ram_wdata;
    logic [COLO_W-1:0]  column;
    logic [VAL_W-1:0]   val_masked;
    logic [M_DATA_W-1:0] tdata_next;
    logic [STAT_W-1:0]  tuser_next;

    assign row_rb  = row_reg - {{(ROW_W-1){1'b0}}, coo_base_reg};
    assign row_bad = (row_reg < {{(ROW_W-1){1'b0}}, coo_base_reg})
                   || (row_rb >= rows_count_reg)
                   || (row_rb >= ROW_W'(MAX_ROWS));
    assign len_lim = (max_row_size_reg > CNT_W'(MAX_ROW_LEN)) ? CNT_W'(MAX_ROW_LEN)
                                                              : max_row_size_reg;
    assign row_full = (pos >= len_lim);

    assign ram_we    = cmd.clear || (cmd.mul && !row_bad && !row_full);
    assign ram_waddr = cmd.clear ? clr_addr_reg : row_rb[ROW_AW-1:0];
    assign ram_wdata = cmd.clear ? '0 : pos + CNT_W'(1);

    c2e_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_ROWS)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (row_rb[ROW_AW-1:0]),
        .rdata (pos)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coo_base_reg      <= 1'b0;
            ell_base_reg      <= 1'b0;
            rows_count_reg    <= ROW_W'(4096);
            max_row_size_reg  <= CNT_W'(1024);
            value_pitch_reg   <= PITCH_W'(4096);
            index_pitch_reg   <= PITCH_W'(4096);
            element_bytes_reg <= EB_W'(8);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_COO_BASE:      coo_base_reg      <= cfg_wr_data[0];
                REG_ELL_BASE:      ell_base_reg      <= cfg_wr_data[0];
                REG_ROWS_COUNT:    rows_count_reg    <= cfg_wr_data[ROW_W-1:0];
                REG_MAX_ROW_SIZE:  max_row_size_reg  <= cfg_wr_data[CNT_W-1:0];
                REG_VALUE_PITCH:   value_pitch_reg   <= cfg_wr_data[PITCH_W-1:0];
                REG_INDEX_PITCH:   index_pitch_reg   <= cfg_wr_data[PITCH_W-1:0];
                REG_ELEMENT_BYTES: element_bytes_reg <= cfg_wr_data[EB_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear) begin
            clr_addr_reg <= clr_addr_reg + ROW_AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg  <= s_tuser;
            row_reg  <= s_tdata[ROW_W-1:0];
            col_reg  <= s_tdata[ROW_W+COL_W-1:ROW_W];
            val_reg  <= s_tdata[ROW_W+COL_W+VAL_W-1:ROW_W+COL_W];
            last_reg <= s_tlast;
        end
        if (cmd.mul) begin
            priority if (row_bad) begin
                status_reg <= ST_ROW_RANGE;
            end else if (row_full) begin
                status_reg <= ST_ROW_FULL;
            end else begin
                status_reg <= ST_WRITTEN;
            end
            prod_i_reg <= PROD_W'(pos * index_pitch_reg);
            prod_v_reg <= PROD_W'(pos * value_pitch_reg);
        end
        if (cmd.add) begin
            slot_reg <= SLOT_W'(PROD_W'(row_rb) + prod_i_reg);
            sumv_reg <= OFF_W'(PROD_W'(row_rb) + prod_v_reg);
        end
        if (cmd.scale) begin
            off_reg <= OFF_W'(sumv_reg * element_bytes_reg);
        end
    end

    assign column = COLO_W'({2'b00, col_reg}) - COLO_W'(coo_base_reg)
                  + COLO_W'(ell_base_reg);

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            val_masked[8*i +: 8] = (element_bytes_reg > EB_W'(i)) ? val_reg[8*i +: 8] : 8'h00;
        end
    end

    always_comb begin
        tdata_next = '0;
        priority if (cmd_reg) begin
            tuser_next = ST_CLEARED;
        end else if (status_reg != ST_WRITTEN) begin
            tuser_next = status_reg;
        end else begin
            tuser_next = ST_WRITTEN;
            tdata_next[SLOT_W-1:0]                      = slot_reg;
            tdata_next[SLOT_W+OFF_W-1:SLOT_W]           = off_reg;
            tdata_next[SLOT_W+OFF_W+COLO_W-1:SLOT_W+OFF_W] = column;
            tdata_next[SLOT_W+OFF_W+COLO_W+VAL_W-1:SLOT_W+OFF_W+COLO_W] = val_masked;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_tdata_reg <= tdata_next;
            m_tuser_reg <= tuser_next;
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign stat.in_clear   = s_tuser;
    assign stat.clear_done = (clr_addr_reg == {ROW_AW{1'b1}});
    assign stat.out_busy   = m_tvalid_reg && !m_tready;

endmodule

@@ rtl/c2e_ctrl.sv @@
// Controller: sequences clearing sweep, entry processing steps and result push.
module c2e_ctrl
    import c2e_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tready && s_tvalid;

    always_comb begin
        state_next = state_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_done) begin
                    state_next = pend_reg ? S_PUSH : S_IDLE;
                    pend_next  = 1'b0;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    if (stat.in_clear) begin
                        state_next = S_CLEAR;
                        pend_next  = 1'b1;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:  state_next = S_MUL;
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD: begin
                cmd.add    = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = S_PUSH;
            end
            S_PUSH: begin
                if (!stat.out_busy) begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
                pend_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

@@ rtl/c2e_checker.sv @@
// Port-level checker for the COO to ELL scatter block, with its bind.
module c2e_checker
    import c2e_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [STAT_W-1:0]   m_tuser
);

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("outputs active after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_WRITTEN |-> m_tdata == '0)
        else $error("non-written result carries data");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while previous in flight");

endmodule

bind coo_to_ell_scatter c2e_checker u_c2e_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
